### rtl/core/pia_pkg.sv
// Shared types, codes and control-register bit positions for the parallel port adapter.
package pia_pkg;

  localparam logic [1:0] FuncRead  = 2'd0;
  localparam logic [1:0] FuncWrite = 2'd1;
  localparam logic [1:0] FuncLine  = 2'd2;
  localparam logic [1:0] FuncPins  = 2'd3;

  localparam logic [1:0] LineC1A = 2'd0;
  localparam logic [1:0] LineC2A = 2'd1;
  localparam logic [1:0] LineC1B = 2'd2;
  localparam logic [1:0] LineC2B = 2'd3;

  localparam int unsigned CrC1Rise  = 1;
  localparam int unsigned CrSelData = 2;
  localparam int unsigned CrC2Rise  = 4;
  localparam int unsigned CrC2Out   = 5;

  localparam int unsigned CtrlW = 6;
  localparam int unsigned DataW = 8;

  typedef struct packed {
    logic [1:0]       func;
    logic [1:0]       addr;
    logic [DataW-1:0] wdata;
    logic [1:0]       line_sel;
    logic             line_level;
  } pia_in_t;

  typedef struct packed {
    logic [DataW-1:0] rdata;
    logic [3:0]       irq_flags;
  } pia_out_t;

  typedef struct packed {
    logic             rd;
    logic             wr;
    logic             ctrl;
    logic             c1_chg;
    logic             c2_chg;
    logic             level;
    logic             pins_wr;
    logic [DataW-1:0] wdata;
  } pia_port_cmd_t;

  typedef struct packed {
    logic [DataW-1:0] rdata;
    logic             flag1;
    logic             flag2;
  } pia_port_sts_t;

endpackage

### rtl/core/parallel_port_interface_adapter.sv
// Top level of the two-port parallel interface adapter with registered input and result stages.
// An accepted item is registered, then processed against the port state as both stages advance
// together, and its result is presented from the result register.
// Throughput is one item per cycle while the result register is empty or its result is taken.
// The input stage is held only while the result register is full and not being taken.
// Reset clears all port registers, flags, held line levels and both stage valid bits.
module parallel_port_interface_adapter import pia_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pia_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pia_out_t out_item_o
);

  logic          s1_valid_q;
  pia_in_t       s1_item_q;
  logic          out_valid_q;
  pia_out_t      res_q, res_d;
  logic          out_load;
  logic          s1_fire;
  logic          in_fire;
  pia_port_cmd_t cmd_a, cmd_b;
  pia_port_sts_t sts_a, sts_b;

  assign out_load   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_load;
  assign in_ready_o = !s1_valid_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    cmd_a         = '0;
    cmd_b         = '0;
    cmd_a.wdata   = s1_item_q.wdata;
    cmd_b.wdata   = s1_item_q.wdata;
    cmd_a.level   = s1_item_q.line_level;
    cmd_b.level   = s1_item_q.line_level;
    cmd_a.ctrl    = s1_item_q.addr[0];
    cmd_b.ctrl    = s1_item_q.addr[0];
    if (s1_fire) begin
      unique case (s1_item_q.func)
        FuncRead: begin
          cmd_a.rd = !s1_item_q.addr[1];
          cmd_b.rd = s1_item_q.addr[1];
        end
        FuncWrite: begin
          cmd_a.wr = !s1_item_q.addr[1];
          cmd_b.wr = s1_item_q.addr[1];
        end
        FuncLine: begin
          cmd_a.c1_chg = (s1_item_q.line_sel == LineC1A);
          cmd_a.c2_chg = (s1_item_q.line_sel == LineC2A);
          cmd_b.c1_chg = (s1_item_q.line_sel == LineC1B);
          cmd_b.c2_chg = (s1_item_q.line_sel == LineC2B);
        end
        FuncPins: begin
          cmd_a.pins_wr = !s1_item_q.addr[1];
          cmd_b.pins_wr = s1_item_q.addr[1];
        end
        default: begin
          cmd_a.rd = 1'b0;
        end
      endcase
    end
  end

  pia_port u_port_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_a),
    .sts_o  (sts_a)
  );

  pia_port u_port_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_b),
    .sts_o  (sts_b)
  );

  assign res_d.rdata     = sts_a.rdata | sts_b.rdata;
  assign res_d.irq_flags = {sts_b.flag2, sts_b.flag1, sts_a.flag2, sts_a.flag1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item_i;
    end
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

  property p_stall_only_when_blocked;
    @(posedge clk_i) disable iff (!rst_ni)
      (s1_valid_q && !s1_fire) |-> (out_valid_q && !out_ready_i);
  endproperty
  assert property (p_stall_only_when_blocked)
    else $error("Input stage held while the result register could load.");

  property p_result_from_stage;
    @(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_q) |-> $past(s1_fire);
  endproperty
  assert property (p_result_from_stage)
    else $error("Result appeared without an item leaving the input stage.");

  property p_rdata_zero_off_read;
    @(posedge clk_i) disable iff (!rst_ni)
      (s1_fire && (s1_item_q.func != FuncRead)) |-> (res_d.rdata == '0);
  endproperty
  assert property (p_rdata_zero_off_read)
    else $error("Nonzero read data for an item that is not a bus read.");

  property p_single_port_read;
    @(posedge clk_i) disable iff (!rst_ni)
      !(cmd_a.rd && cmd_b.rd);
  endproperty
  assert property (p_single_port_read)
    else $error("Both ports selected for one read.");

endmodule

### rtl/core/pia_port.sv
// One port of the adapter: its registers, control-line edge flags and read view.
module pia_port import pia_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pia_port_cmd_t cmd_i,
  output pia_port_sts_t sts_o
);

  logic [CtrlW-1:0] ctrl_q, ctrl_d;
  logic [DataW-1:0] out_q, out_d;
  logic [DataW-1:0] dir_q, dir_d;
  logic [DataW-1:0] pins_q, pins_d;
  logic             flag1_q, flag1_d;
  logic             flag2_q, flag2_d;
  logic             lvl1_q, lvl1_d;
  logic             lvl2_q, lvl2_d;
  logic             sel_data;
  logic [DataW-1:0] rd_view;

  assign sel_data = ctrl_q[CrSelData];

  always_comb begin
    if (cmd_i.ctrl) begin
      rd_view = {flag1_q, flag2_q & ~ctrl_q[CrC2Out], ctrl_q};
    end else if (sel_data) begin
      rd_view = (pins_q & ~dir_q) | (out_q & dir_q);
    end else begin
      rd_view = dir_q;
    end
  end

  always_comb begin
    ctrl_d  = ctrl_q;
    out_d   = out_q;
    dir_d   = dir_q;
    pins_d  = pins_q;
    flag1_d = flag1_q;
    flag2_d = flag2_q;
    lvl1_d  = lvl1_q;
    lvl2_d  = lvl2_q;
    if (cmd_i.rd && !cmd_i.ctrl && sel_data) begin
      flag1_d = 1'b0;
      flag2_d = 1'b0;
    end
    if (cmd_i.wr) begin
      if (cmd_i.ctrl) begin
        ctrl_d = cmd_i.wdata[CtrlW-1:0];
      end else if (sel_data) begin
        out_d = cmd_i.wdata;
      end else begin
        dir_d = cmd_i.wdata;
      end
    end
    if (cmd_i.pins_wr) begin
      pins_d = cmd_i.wdata;
    end
    if (cmd_i.c1_chg && (cmd_i.level != lvl1_q)) begin
      lvl1_d = cmd_i.level;
      if (cmd_i.level == ctrl_q[CrC1Rise]) begin
        flag1_d = 1'b1;
      end
    end
    if (cmd_i.c2_chg && !ctrl_q[CrC2Out] && (cmd_i.level != lvl2_q)) begin
      lvl2_d = cmd_i.level;
      if (cmd_i.level == ctrl_q[CrC2Rise]) begin
        flag2_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= '0;
      out_q   <= '0;
      dir_q   <= '0;
      pins_q  <= '0;
      flag1_q <= 1'b0;
      flag2_q <= 1'b0;
      lvl1_q  <= 1'b0;
      lvl2_q  <= 1'b0;
    end else begin
      ctrl_q  <= ctrl_d;
      out_q   <= out_d;
      dir_q   <= dir_d;
      pins_q  <= pins_d;
      flag1_q <= flag1_d;
      flag2_q <= flag2_d;
      lvl1_q  <= lvl1_d;
      lvl2_q  <= lvl2_d;
    end
  end

  assign sts_o.rdata = cmd_i.rd ? rd_view : '0;
  assign sts_o.flag1 = flag1_d;
  assign sts_o.flag2 = flag2_d;

endmodule

### tb/sv/tb_parallel_port_interface_adapter.sv
// Self-checking testbench for the parallel port adapter: queued stimulus, predictor, monitor.
`timescale 1ns / 1ps

module tb_parallel_port_interface_adapter;
  import pia_pkg::*;

  localparam logic [1:0] AddrDataA = 2'd0;
  localparam logic [1:0] AddrCtrlA = 2'd1;
  localparam logic [1:0] AddrDataB = 2'd2;
  localparam logic [1:0] AddrCtrlB = 2'd3;

  localparam int unsigned PhaseItems   = 325;
  localparam int unsigned RxHoldCycles = 60;
  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned TailCycles   = 8;

  typedef enum int {
    PhaseDirected,
    PhaseRecvSlow,
    PhaseSendSlow,
    PhaseFree
  } run_phase_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  pia_in_t  in_item_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  pia_out_t out_item_o;

  pia_in_t    pending_items[$];
  pia_out_t   expected_results[$];
  run_phase_e run_phase     = PhaseDirected;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         fail_count    = 0;
  int         idle_cycles   = 0;
  logic       in_taken      = 1'b0;
  logic       out_taken     = 1'b0;
  int         rx_hold_left  = 0;
  logic       rx_hold_done  = 1'b0;

  logic [CtrlW-1:0] port_ctl  [2] = '{default: '0};
  logic [DataW-1:0] port_out  [2] = '{default: '0};
  logic [DataW-1:0] port_dir  [2] = '{default: '0};
  logic [DataW-1:0] port_pins [2] = '{default: '0};
  logic             flag1     [2] = '{default: 1'b0};
  logic             flag2     [2] = '{default: 1'b0};
  logic             c1_held   [2] = '{default: 1'b0};
  logic             c2_held   [2] = '{default: 1'b0};

  parallel_port_interface_adapter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #5ns clk_i = ~clk_i;

  function automatic pia_out_t pia_predict(pia_in_t it);
    pia_out_t res;
    int       p;
    res = '0;
    p = it.addr[1];
    case (it.func)
      FuncRead: begin
        if (it.addr[0]) begin
          res.rdata = {flag1[p], flag2[p] & ~port_ctl[p][CrC2Out], port_ctl[p]};
        end else if (port_ctl[p][CrSelData]) begin
          res.rdata = (port_pins[p] & ~port_dir[p]) | (port_out[p] & port_dir[p]);
          flag1[p] = 1'b0;
          flag2[p] = 1'b0;
        end else begin
          res.rdata = port_dir[p];
        end
      end
      FuncWrite: begin
        if (it.addr[0]) begin
          port_ctl[p] = it.wdata[CtrlW-1:0];
        end else if (port_ctl[p][CrSelData]) begin
          port_out[p] = it.wdata;
        end else begin
          port_dir[p] = it.wdata;
        end
      end
      FuncLine: begin
        p = it.line_sel[1];
        if (!it.line_sel[0]) begin
          if (c1_held[p] != it.line_level) begin
            if (it.line_level == port_ctl[p][CrC1Rise]) flag1[p] = 1'b1;
            c1_held[p] = it.line_level;
          end
        end else if (c2_held[p] != it.line_level && !port_ctl[p][CrC2Out]) begin
          if (it.line_level == port_ctl[p][CrC2Rise]) flag2[p] = 1'b1;
          c2_held[p] = it.line_level;
        end
      end
      default: begin
        port_pins[p] = it.wdata;
      end
    endcase
    res.irq_flags = {flag2[1], flag1[1], flag2[0], flag1[0]};
    return res;
  endfunction

  function automatic pia_in_t random_item();
    pia_in_t it;
    it.func       = 2'($urandom_range(3));
    it.addr       = 2'($urandom_range(3));
    it.wdata      = 8'($urandom);
    it.line_sel   = 2'($urandom_range(3));
    it.line_level = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic add_item(input logic [1:0] func, input logic [1:0] addr,
                          input logic [7:0] wdata, input logic [1:0] sel, input logic lvl);
    pia_in_t it;
    it.func       = func;
    it.addr       = addr;
    it.wdata      = wdata;
    it.line_sel   = sel;
    it.line_level = lvl;
    pending_items.push_back(it);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic wait_until_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin : drive_items
    logic    next_valid;
    pia_in_t next_item;
    next_valid = in_valid_i && !in_taken;
    next_item  = in_item_i;
    if (!next_valid && pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      next_item  = pending_items.pop_front();
      next_valid = 1'b1;
    end
    in_valid_i <= next_valid;
    in_item_i  <= next_item;
  end

  always @(negedge clk_i) begin : drive_ready
    logic next_ready;
    if (rx_hold_left > 0) begin
      next_ready = 1'b0;
      rx_hold_left--;
    end else if (run_phase == PhaseFree && !rx_hold_done && pending_items.size() != 0) begin
      next_ready   = 1'b0;
      rx_hold_done = 1'b1;
      rx_hold_left = RxHoldCycles - 1;
    end else begin
      next_ready = $urandom_range(99) >= recv_idle_pct;
    end
    out_ready_i <= next_ready;
  end

  always @(posedge clk_i) begin : watch_items
    pia_out_t want;
    if (rst_ni) begin
      in_taken  = in_valid_i && in_ready_o;
      out_taken = out_valid_o && out_ready_i;
      if (out_taken) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with none pending, rdata", out_item_o.rdata, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_item_o.rdata !== want.rdata)
            report_mismatch("rdata", out_item_o.rdata, want.rdata);
          if (out_item_o.irq_flags !== want.irq_flags)
            report_mismatch("irq_flags", out_item_o.irq_flags, want.irq_flags);
        end
      end
      if (in_taken) expected_results.push_back(pia_predict(in_item_i));
      idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= StallLimit);
    $display("stalled for %0d cycles at %0t", StallLimit, $realtime);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    add_item(FuncRead,  AddrCtrlA, 8'h00, LineC1A, 1'b0);
    add_item(FuncRead,  AddrDataA, 8'hFF, LineC2B, 1'b1);
    add_item(FuncWrite, AddrDataA, 8'hF0, LineC1A, 1'b0);
    add_item(FuncRead,  AddrDataA, 8'h00, LineC1A, 1'b0);
    add_item(FuncWrite, AddrCtrlA, 8'hFF, LineC1A, 1'b0);
    add_item(FuncRead,  AddrCtrlA, 8'h00, LineC1A, 1'b0);
    add_item(FuncWrite, AddrDataA, 8'hA5, LineC1A, 1'b0);
    add_item(FuncPins,  AddrCtrlA, 8'h5A, LineC1A, 1'b0);
    add_item(FuncRead,  AddrDataA, 8'h00, LineC1A, 1'b0);
    add_item(FuncLine,  AddrDataA, 8'h00, LineC1A, 1'b1);
    add_item(FuncLine,  AddrDataA, 8'h00, LineC1A, 1'b1);
    add_item(FuncLine,  AddrDataA, 8'h00, LineC2A, 1'b1);
    add_item(FuncRead,  AddrCtrlA, 8'h00, LineC1A, 1'b0);
    add_item(FuncRead,  AddrDataA, 8'h00, LineC1A, 1'b0);
    add_item(FuncWrite, AddrCtrlA, 8'hC4, LineC1A, 1'b0);
    add_item(FuncLine,  AddrDataA, 8'h00, LineC2A, 1'b1);
    add_item(FuncLine,  AddrDataA, 8'h00, LineC2A, 1'b0);
    add_item(FuncLine,  AddrDataA, 8'h00, LineC1A, 1'b0);
    add_item(FuncRead,  AddrCtrlA, 8'h00, LineC1A, 1'b0);
    add_item(FuncWrite, AddrCtrlB, 8'h12, LineC1B, 1'b0);
    add_item(FuncWrite, AddrDataB, 8'h00, LineC1B, 1'b0);
    add_item(FuncWrite, AddrCtrlB, 8'h16, LineC1B, 1'b0);
    add_item(FuncPins,  AddrDataB, 8'hFF, LineC1B, 1'b0);
    add_item(FuncLine,  AddrDataB, 8'h00, LineC1B, 1'b1);
    add_item(FuncLine,  AddrDataB, 8'h00, LineC2B, 1'b1);
    add_item(FuncRead,  AddrCtrlB, 8'h00, LineC1B, 1'b0);
    add_item(FuncRead,  AddrDataB, 8'h00, LineC1B, 1'b0);
    wait_until_drained();

    run_phase     = PhaseRecvSlow;
    send_idle_pct = 18;
    recv_idle_pct = 71;
    repeat (PhaseItems) pending_items.push_back(random_item());
    wait_until_drained();

    run_phase     = PhaseSendSlow;
    send_idle_pct = 71;
    recv_idle_pct = 18;
    repeat (PhaseItems) pending_items.push_back(random_item());
    wait_until_drained();

    run_phase     = PhaseFree;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (PhaseItems) pending_items.push_back(random_item());
    wait_until_drained();

    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
